@@ src/assert_macros.svh @@
// Assertion macros included by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that holds at every clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPLY(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error(msg);

`endif

@@ src/spq_pkg.sv @@
// Types and constants of the sorted priority queue.
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

	localparam int CAPACITY = 16;
	localparam int COUNT_W = 5;
	localparam int YEAR_W = 14;
	localparam int MONTH_W = 4;
	localparam int DAY_W = 5;
	localparam int TAG_W = 16;

	typedef enum logic [0:0] {
		OP_PUSH = 1'b0,
		OP_POP = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	typedef struct packed {
		logic [YEAR_W-1:0] year;
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0] day;
		logic [TAG_W-1:0] tag;
	} entry_t;

	typedef struct packed {
		op_t opcode;
		logic [YEAR_W-1:0] key_year;
		logic [MONTH_W-1:0] key_month;
		logic [DAY_W-1:0] key_day;
		logic [TAG_W-1:0] name_tag;
	} in_t;

	typedef struct packed {
		status_t status;
		logic [YEAR_W-1:0] out_year;
		logic [MONTH_W-1:0] out_month;
		logic [DAY_W-1:0] out_day;
		logic [TAG_W-1:0] out_tag;
		logic [COUNT_W-1:0] occupancy;
	} out_t;

	typedef struct packed {
		logic push;
		logic pop;
		entry_t new_entry;
	} cell_ctrl_t;

endpackage

`default_nettype wire

@@ src/spq_cell.sv @@
// One queue cell: holds an entry, shifts right on insert, left on pop.
`timescale 1ns / 1ps
`default_nettype none

module spq_cell (
	input wire logic clk,
	input wire logic arst_n,
	input wire spq_pkg::cell_ctrl_t ctrl,
	input wire spq_pkg::entry_t prev_entry,
	input wire logic prev_valid,
	input wire logic prev_keep,
	input wire spq_pkg::entry_t next_entry,
	input wire logic next_valid,
	output spq_pkg::entry_t entry,
	output logic valid,
	output logic keep
);

	spq_pkg::entry_t entry_q;
	logic valid_q;

	// entry stays put when its year is strictly below the new key's year
	assign keep = valid_q && (entry_q.year < ctrl.new_entry.year);
	assign entry = entry_q;
	assign valid = valid_q;

	always_ff @(posedge clk) begin
		if (ctrl.push && !keep) begin
			entry_q <= prev_keep ? ctrl.new_entry : prev_entry;
		end else if (ctrl.pop) begin
			entry_q <= next_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.push) begin
			valid_q <= valid_q | prev_valid;
		end else if (ctrl.pop) begin
			valid_q <= next_valid;
		end
	end

endmodule

`default_nettype wire

@@ src/sorted_priority_queue_top.sv @@
// Top level of the sorted priority queue: cell chain, count and result register.
//
//  channel | direction | payload          | handshake
//  in      | input     | spq_pkg::in_t    | in_valid / in_stall
//  out     | output    | spq_pkg::out_t   | out_valid / out_stall
//
// One item per cycle while in_stall is low: a push or pop updates every cell of the chain at once.
// The result is registered and appears in the cycle after the transfer.
// in_stall is raised while a result waits and out_stall is high.
// Reset clears all valid bits, the count and the result register valid.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module sorted_priority_queue_top (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire spq_pkg::in_t in_data,
	output logic out_valid,
	input wire logic out_stall,
	output spq_pkg::out_t out_data
);

	spq_pkg::entry_t entry_vec [spq_pkg::CAPACITY];
	logic [spq_pkg::CAPACITY-1:0] valid_vec;
	logic [spq_pkg::CAPACITY-1:0] keep_vec;
	logic [spq_pkg::CAPACITY:0] valid_inc;
	spq_pkg::cell_ctrl_t ctrl;
	logic [spq_pkg::COUNT_W-1:0] count_q;
	logic [spq_pkg::COUNT_W-1:0] count_next;
	logic out_valid_q;
	spq_pkg::out_t out_q;
	spq_pkg::out_t result;
	logic accept;
	logic full;
	logic empty;

	assign in_stall = out_valid_q && out_stall;
	assign accept = in_valid && !in_stall;
	assign full = (count_q == spq_pkg::COUNT_W'(spq_pkg::CAPACITY));
	assign empty = (count_q == '0);

	always_comb begin
		ctrl.new_entry.year = in_data.key_year;
		ctrl.new_entry.month = in_data.key_month;
		ctrl.new_entry.day = in_data.key_day;
		ctrl.new_entry.tag = in_data.name_tag;
		ctrl.push = accept && (in_data.opcode == spq_pkg::OP_PUSH) && !full;
		ctrl.pop = accept && (in_data.opcode == spq_pkg::OP_POP) && !empty;

		count_next = count_q;
		if (ctrl.push) begin
			count_next = count_q + 1'b1;
		end else if (ctrl.pop) begin
			count_next = count_q - 1'b1;
		end

		result = '0;
		result.status = spq_pkg::ST_OK;
		result.occupancy = count_next;
		if (in_data.opcode == spq_pkg::OP_PUSH) begin
			if (full) begin
				result.status = spq_pkg::ST_FULL;
			end
		end else if (empty) begin
			result.status = spq_pkg::ST_EMPTY;
		end else begin
			result.out_year = entry_vec[0].year;
			result.out_month = entry_vec[0].month;
			result.out_day = entry_vec[0].day;
			result.out_tag = entry_vec[0].tag;
		end
	end

	for (genvar i = 0; i < spq_pkg::CAPACITY; i++) begin : g_cell
		spq_pkg::entry_t prev_entry;
		logic prev_valid;
		logic prev_keep;
		spq_pkg::entry_t next_entry;
		logic next_valid;

		if (i == 0) begin : g_head
			assign prev_entry = ctrl.new_entry;
			assign prev_valid = 1'b1;
			assign prev_keep = 1'b1;
		end else begin : g_body
			assign prev_entry = entry_vec[i-1];
			assign prev_valid = valid_vec[i-1];
			assign prev_keep = keep_vec[i-1];
		end

		if (i == spq_pkg::CAPACITY - 1) begin : g_tail
			assign next_entry = entry_vec[i];
			assign next_valid = 1'b0;
		end else begin : g_inner
			assign next_entry = entry_vec[i+1];
			assign next_valid = valid_vec[i+1];
		end

		spq_cell u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.ctrl(ctrl),
			.prev_entry(prev_entry),
			.prev_valid(prev_valid),
			.prev_keep(prev_keep),
			.next_entry(next_entry),
			.next_valid(next_valid),
			.entry(entry_vec[i]),
			.valid(valid_vec[i]),
			.keep(keep_vec[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_next;
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

	assign valid_inc = {1'b0, valid_vec} + 1'b1;

	`ASSERT_ALWAYS(a_count_matches, clk, arst_n,
		count_q == spq_pkg::COUNT_W'($countones(valid_vec)), "count differs from valid cells")
	`ASSERT_ALWAYS(a_valid_prefix, clk, arst_n,
		$onehot(valid_inc), "valid cells are not a prefix")
	`ASSERT_IMPLY(a_head_order, clk, arst_n, valid_vec[1],
		entry_vec[0].year <= entry_vec[1].year, "front cells out of order")
	`ASSERT_IMPLY(a_empty_zero, clk, arst_n,
		out_valid_q && (out_q.status == spq_pkg::ST_EMPTY),
		(out_q.out_year == '0) && (out_q.out_tag == '0) && (out_q.occupancy == '0),
		"empty pop result not cleared")

endmodule

`default_nettype wire
